// File: rtl/pits_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pits_pkg
// Types and codes shared by the priority interval task scheduler.
// ----------------------------------------------------------------------------
package pits_pkg;

  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned RES_CW       = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_KILL   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_RUN       = 3'd0,
    EV_CREATED   = 3'd1,
    EV_FULL      = 3'd2,
    EV_KILLED    = 3'd3,
    EV_NOT_FOUND = 3'd4
  } event_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [3:0]  priority_req;
    logic [15:0] target_pid;
    logic        interrupt_pending;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] task_pid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] interval;
    logic [31:0] last_run;
    logic [3:0]  prio;
  } entry_t;

  typedef struct packed {
    logic due;
    logic prio_after;
    logic pid_hit;
  } eval_t;

endpackage
`default_nettype wire

// File: rtl/pits_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pits_table
// Task table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pits_table #(
  parameter int unsigned TASK_SLOTS = 16,
  parameter int unsigned AW         = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire pits_pkg::entry_t wdata,
  input  wire logic [AW-1:0]    raddr,
  output pits_pkg::entry_t      rdata
);
  import pits_pkg::*;

  entry_t mem [TASK_SLOTS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/pits_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pits_eval
// Shared compare unit: due test, priority order and pid match on one entry.
// ----------------------------------------------------------------------------
module pits_eval (
  input  wire pits_pkg::entry_t entry,
  input  wire logic [31:0]      now_ms,
  input  wire logic [3:0]       prio,
  input  wire logic [15:0]      target_pid,
  output pits_pkg::eval_t       flags
);
  import pits_pkg::*;

  logic [31:0] elapsed;

  assign elapsed          = now_ms - entry.last_run;
  assign flags.due        = (elapsed >= entry.interval);
  assign flags.prio_after = (entry.prio > prio);
  assign flags.pid_hit    = (entry.pid == target_pid);

endmodule
`default_nettype wire

// File: rtl/priority_interval_task_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_interval_task_scheduler_core
// Priority-ordered periodic task table with create, kill and tick commands.
//
//   channel  ports                       handshake
//   input    start, busy, in_data        taken when start && !busy
//   result   out_valid, out_data         one-cycle strobe, always taken
//
// One table entry is read per cycle through the single table read port.
// Tick: every entry is scanned, then ST_FIN gives the last result; interrupt
// tick: the scan stops at the first due entry, held for the next tick. Kill:
// every entry is scanned. Create: entries with a larger prio shift up from the
// end, then ST_INS writes. Reset (rst_n low, synchronous) empties the table.
// busy drops in the cycle the last result is on the ports; no result stalls.
// ----------------------------------------------------------------------------
module priority_interval_task_scheduler_core #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire pits_pkg::in_item_t in_data,
  output      logic             out_valid,
  output pits_pkg::out_item_t   out_data
);
  import pits_pkg::*;

  localparam int unsigned AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [AW-1:0] ONE_A = AW'(1);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(TASK_SLOTS);
  localparam logic [RES_CW-1:0] LIMIT_R = RES_CW'(RESULT_LIMIT);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_INS  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_IRQ,
    OP_TICK,
    OP_CREATE,
    OP_KILL
  } op_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [15:0]       next_pid_r, next_pid_nxt;
  logic              held_v_r, held_v_nxt;
  logic [AW-1:0]     held_slot_r, held_slot_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     kidx_r, kidx_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [15:0]       pend_pid_r, pend_pid_nxt;
  logic [RES_CW-1:0] nres_r, nres_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [31:0]       intv_r, intv_nxt;
  logic [3:0]        prio_r, prio_nxt;
  logic [15:0]       target_r, target_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  entry_t            rdata;
  eval_t             ev;
  entry_t            new_entry;
  logic [AW-1:0]     last_idx;
  logic              fin;
  logic              hit;
  logic [AW-1:0]     kpos;

  pits_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .AW         (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pits_eval u_eval (
    .entry      (rdata),
    .now_ms     (now_r),
    .prio       (prio_r),
    .target_pid (target_r),
    .flags      (ev)
  );

  assign last_idx           = AW'(cnt_r - ONE_C);
  assign fin                = (ptr_r == last_idx);
  assign hit                = !found_r && ev.pid_hit;
  assign kpos               = hit ? ptr_r : kidx_r;
  assign new_entry.pid      = next_pid_r;
  assign new_entry.interval = intv_r;
  assign new_entry.last_run = now_r;
  assign new_entry.prio     = prio_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    next_pid_nxt  = next_pid_r;
    held_v_nxt    = held_v_r;
    held_slot_nxt = held_slot_r;
    found_nxt     = found_r;
    kidx_nxt      = kidx_r;
    pend_v_nxt    = pend_v_r;
    pend_pid_nxt  = pend_pid_r;
    nres_nxt      = nres_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    now_nxt       = now_r;
    intv_nxt      = intv_r;
    prio_nxt      = prio_r;
    target_nxt    = target_r;
    we            = 1'b0;
    waddr         = ptr_r;
    wdata         = rdata;
    raddr         = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          now_nxt    = in_data.now_ms;
          intv_nxt   = in_data.interval_ms;
          prio_nxt   = in_data.priority_req;
          target_nxt = in_data.target_pid;
          unique case (in_data.command)
            CMD_TICK: begin
              if (held_v_r) begin
                held_v_nxt = 1'b0;
                if (CW'(held_slot_r) < cnt_r) begin
                  op_nxt    = OP_HOLD;
                  ptr_nxt   = held_slot_r;
                  raddr     = held_slot_r;
                  state_nxt = ST_SCAN;
                end
              end else if (cnt_r != '0) begin
                op_nxt     = in_data.interrupt_pending ? OP_IRQ : OP_TICK;
                ptr_nxt    = '0;
                raddr      = '0;
                nres_nxt   = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = ST_SCAN;
              end
            end
            CMD_CREATE: begin
              if (cnt_r == FULL_C) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.event_res = EV_FULL;
                out_data_nxt.task_pid  = '0;
                out_data_nxt.last      = 1'b1;
              end else if (cnt_r == '0) begin
                pos_nxt   = '0;
                state_nxt = ST_INS;
              end else begin
                op_nxt    = OP_CREATE;
                ptr_nxt   = last_idx;
                raddr     = last_idx;
                state_nxt = ST_SCAN;
              end
            end
            CMD_KILL: begin
              if (cnt_r == '0) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.event_res = EV_NOT_FOUND;
                out_data_nxt.task_pid  = in_data.target_pid;
                out_data_nxt.last      = 1'b1;
              end else begin
                op_nxt    = OP_KILL;
                ptr_nxt   = '0;
                raddr     = '0;
                found_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        unique case (op_r)
          OP_HOLD: begin
            we                     = 1'b1;
            wdata.last_run         = now_r;
            out_valid_nxt          = 1'b1;
            out_data_nxt.event_res = EV_RUN;
            out_data_nxt.task_pid  = rdata.pid;
            out_data_nxt.last      = 1'b1;
            state_nxt              = ST_IDLE;
          end
          OP_IRQ: begin
            if (ev.due) begin
              held_v_nxt    = 1'b1;
              held_slot_nxt = ptr_r;
              state_nxt     = ST_IDLE;
            end else if (fin) begin
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt = ptr_r + ONE_A;
              raddr   = ptr_r + ONE_A;
            end
          end
          OP_TICK: begin
            if (ev.due && (nres_r < LIMIT_R)) begin
              we             = 1'b1;
              wdata.last_run = now_r;
              if (pend_v_r) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.event_res = EV_RUN;
                out_data_nxt.task_pid  = pend_pid_r;
                out_data_nxt.last      = 1'b0;
              end
              pend_v_nxt   = 1'b1;
              pend_pid_nxt = rdata.pid;
              nres_nxt     = nres_r + RES_CW'(1);
            end
            if (fin) begin
              state_nxt = ST_FIN;
            end else begin
              ptr_nxt = ptr_r + ONE_A;
              raddr   = ptr_r + ONE_A;
            end
          end
          OP_CREATE: begin
            if (ev.prio_after) begin
              we    = 1'b1;
              waddr = ptr_r + ONE_A;
              if (ptr_r == '0) begin
                pos_nxt   = '0;
                state_nxt = ST_INS;
              end else begin
                ptr_nxt = ptr_r - ONE_A;
                raddr   = ptr_r - ONE_A;
              end
            end else begin
              pos_nxt   = ptr_r + ONE_A;
              state_nxt = ST_INS;
            end
          end
          OP_KILL: begin
            if (found_r) begin
              we    = 1'b1;
              waddr = ptr_r - ONE_A;
            end
            if (hit) begin
              found_nxt = 1'b1;
              kidx_nxt  = ptr_r;
            end
            if (fin) begin
              state_nxt             = ST_IDLE;
              out_valid_nxt         = 1'b1;
              out_data_nxt.task_pid = target_r;
              out_data_nxt.last     = 1'b1;
              if (found_r || hit) begin
                cnt_nxt                = cnt_r - ONE_C;
                out_data_nxt.event_res = EV_KILLED;
                if (held_v_r) begin
                  if (held_slot_r == kpos) begin
                    held_v_nxt = 1'b0;
                  end else if (held_slot_r > kpos) begin
                    held_slot_nxt = held_slot_r - ONE_A;
                  end
                end
              end else begin
                out_data_nxt.event_res = EV_NOT_FOUND;
              end
            end else begin
              ptr_nxt = ptr_r + ONE_A;
              raddr   = ptr_r + ONE_A;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_INS: begin
        we                     = 1'b1;
        waddr                  = pos_r;
        wdata                  = new_entry;
        cnt_nxt                = cnt_r + ONE_C;
        if (held_v_r && (pos_r <= held_slot_r)) begin
          held_slot_nxt = held_slot_r + ONE_A;
        end
        out_valid_nxt          = 1'b1;
        out_data_nxt.event_res = EV_CREATED;
        out_data_nxt.task_pid  = next_pid_r;
        out_data_nxt.last      = 1'b1;
        next_pid_nxt           = next_pid_r + 16'd1;
        state_nxt              = ST_IDLE;
      end

      ST_FIN: begin
        if (pend_v_r) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.event_res = EV_RUN;
          out_data_nxt.task_pid  = pend_pid_r;
          out_data_nxt.last      = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_TICK;
      ptr_r       <= '0;
      cnt_r       <= '0;
      next_pid_r  <= '0;
      held_v_r    <= 1'b0;
      held_slot_r <= '0;
      found_r     <= 1'b0;
      kidx_r      <= '0;
      pend_v_r    <= 1'b0;
      nres_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      next_pid_r  <= next_pid_nxt;
      held_v_r    <= held_v_nxt;
      held_slot_r <= held_slot_nxt;
      found_r     <= found_nxt;
      kidx_r      <= kidx_nxt;
      pend_v_r    <= pend_v_nxt;
      nres_r      <= nres_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_pid_r <= pend_pid_nxt;
    out_data_r <= out_data_nxt;
    now_r      <= now_nxt;
    intv_r     <= intv_nxt;
    prio_r     <= prio_nxt;
    target_r   <= target_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: tb/priority_interval_task_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_interval_task_scheduler_core_tb
// Self-checking bench for the task scheduler core. Directed create, kill and
// tick commands cover ordering, holds and wrap-around times. A short burst of
// back-to-back create and kill pairs and random traffic with input gaps
// follow. Every result is compared against a behavioural copy of the table.
// ----------------------------------------------------------------------------

localparam int unsigned SCHED_SLOTS = 16;

class sched_scoreboard;
  pits_pkg::entry_t    slots[SCHED_SLOTS];
  int unsigned         task_cnt;
  logic [15:0]         next_id;
  bit                  hold_on;
  int unsigned         hold_idx;
  pits_pkg::out_item_t batch[$];
  pits_pkg::out_item_t expected_events[$];
  int unsigned         errors, checked, commands, full_seen, holds_taken;

  function new();
    task_cnt    = 0;
    next_id     = '0;
    hold_on     = 1'b0;
    hold_idx    = 0;
    errors      = 0;
    checked     = 0;
    commands    = 0;
    full_seen   = 0;
    holds_taken = 0;
  endfunction

  function void add_event(input pits_pkg::event_t code, input logic [15:0] pid);
    pits_pkg::out_item_t ev;
    ev.event_res = code;
    ev.task_pid  = pid;
    ev.last      = 1'b0;
    batch.push_back(ev);
  endfunction

  function void run_tick(input logic [31:0] now, input logic irq);
    logic [31:0] elapsed;
    int unsigned i;
    if (hold_on) begin
      hold_on = 1'b0;
      if (hold_idx < task_cnt) begin
        slots[hold_idx].last_run = now;
        add_event(pits_pkg::EV_RUN, slots[hold_idx].pid);
      end
    end else if (irq) begin
      for (i = 0; i < task_cnt && !hold_on; i++) begin
        elapsed = now - slots[i].last_run;
        if (elapsed >= slots[i].interval) begin
          hold_on  = 1'b1;
          hold_idx = i;
          holds_taken++;
        end
      end
    end else begin
      for (i = 0; i < task_cnt && batch.size() < pits_pkg::RESULT_LIMIT; i++) begin
        elapsed = now - slots[i].last_run;
        if (elapsed >= slots[i].interval) begin
          slots[i].last_run = now;
          add_event(pits_pkg::EV_RUN, slots[i].pid);
        end
      end
    end
  endfunction

  function void run_create(input pits_pkg::in_item_t item);
    int unsigned pos, i;
    if (task_cnt >= SCHED_SLOTS) begin
      add_event(pits_pkg::EV_FULL, 16'h0000);
      full_seen++;
    end else begin
      pos = 0;
      while (pos < task_cnt && slots[pos].prio <= item.priority_req) pos++;
      for (i = task_cnt; i > pos; i--) slots[i] = slots[i - 1];
      slots[pos].pid      = next_id;
      slots[pos].interval = item.interval_ms;
      slots[pos].last_run = item.now_ms;
      slots[pos].prio     = item.priority_req;
      task_cnt++;
      if (hold_on && pos <= hold_idx) hold_idx++;
      add_event(pits_pkg::EV_CREATED, next_id);
      next_id++;
    end
  endfunction

  function void run_kill(input logic [15:0] pid);
    int unsigned i, j;
    bit hit;
    hit = 1'b0;
    for (i = 0; i < task_cnt && !hit; i++) begin
      if (slots[i].pid == pid) begin
        hit = 1'b1;
        for (j = i; j + 1 < task_cnt; j++) slots[j] = slots[j + 1];
        task_cnt--;
        if (hold_on) begin
          if (hold_idx == i) hold_on = 1'b0;
          else if (hold_idx > i) hold_idx--;
        end
        add_event(pits_pkg::EV_KILLED, pid);
      end
    end
    if (!hit) add_event(pits_pkg::EV_NOT_FOUND, pid);
  endfunction

  // accepted transaction: update the table copy and queue its results
  function void note_command(input pits_pkg::in_item_t item);
    batch.delete();
    case (item.command)
      pits_pkg::CMD_TICK:   run_tick(item.now_ms, item.interrupt_pending);
      pits_pkg::CMD_CREATE: run_create(item);
      pits_pkg::CMD_KILL:   run_kill(item.target_pid);
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
    commands++;
  endfunction

  function void check_event(input pits_pkg::out_item_t got);
    pits_pkg::out_item_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected result: event_res %0d task_pid %0d last %0d",
             got.event_res, got.task_pid, got.last);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    checked++;
    if (got.event_res !== want.event_res) begin
      $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
      errors++;
    end
    if (got.task_pid !== want.task_pid) begin
      $error("task_pid: expected %0d, actual %0d", want.task_pid, got.task_pid);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction

  function bit pick_live_pid(output logic [15:0] pid);
    pid = '0;
    if (task_cnt == 0) return 1'b0;
    pid = slots[$urandom_range(task_cnt - 1, 0)].pid;
    return 1'b1;
  endfunction
endclass

module priority_interval_task_scheduler_core_tb;
  import pits_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned RANDOM_ITEMS   = 176;
  localparam int unsigned PAIR_COUNT     = 4;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  sched_scoreboard sb;
  bit              gaps_on;
  logic [31:0]     now_t;
  int unsigned     idle_cycles = 0;

  priority_interval_task_scheduler_core #(
    .TASK_SLOTS(SCHED_SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_event(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t tick_cmd(input logic [31:0] now, input logic irq);
    in_item_t item;
    item                   = noise_item();
    item.command           = CMD_TICK;
    item.now_ms            = now;
    item.interrupt_pending = irq;
    return item;
  endfunction

  function automatic in_item_t create_cmd(input logic [31:0] now, input logic [31:0] ivl,
                                          input logic [3:0] prio);
    in_item_t item;
    item              = noise_item();
    item.command      = CMD_CREATE;
    item.now_ms       = now;
    item.interval_ms  = ivl;
    item.priority_req = prio;
    return item;
  endfunction

  function automatic in_item_t kill_cmd(input logic [15:0] pid);
    in_item_t item;
    item            = noise_item();
    item.command    = CMD_KILL;
    item.target_pid = pid;
    return item;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(input in_item_t item);
    while (gaps_on && $urandom_range(99, 0) < 38) begin
      start   = 1'b0;
      in_data = noise_item();
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = item;
    do @(posedge clk); while (busy);
    sb.note_command(item);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] pid, first_pid;
    logic [31:0] now_v, ivl;
    int unsigned n, r, r2, phase, c_w, t_w, wait_n;
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    gaps_on = 1'b1;
    now_t   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, unused code, then ordering, holds and time wrap
    send(tick_cmd(32'h0000_0000, 1'b0));
    send(tick_cmd(32'hFFFF_FFFF, 1'b1));
    send(kill_cmd(16'hFFFF));
    send(in_item_t'('1));
    send(create_cmd(32'h0, 32'hFFFF_FFFF, 4'hF));
    send(create_cmd(32'h0, 32'h0, 4'h0));
    send(create_cmd(32'h0, 32'd100, 4'h7));
    send(create_cmd(32'h0, 32'd1000, 4'h0));
    send(tick_cmd(32'd50, 1'b0));
    send(tick_cmd(32'hFFFF_FFFF, 1'b0));
    send(kill_cmd(16'd1));
    send(tick_cmd(32'd5, 1'b1));
    send(tick_cmd(32'd200, 1'b1));
    send(create_cmd(32'd200, 32'hFFFF_FFFF, 4'h0));
    send(kill_cmd(16'd3));
    send(tick_cmd(32'd300, 1'b0));
    send(tick_cmd(32'd400, 1'b1));
    send(kill_cmd(16'd2));
    send(tick_cmd(32'd400, 1'b0));
    send(kill_cmd(16'd2));
    send(create_cmd($urandom, $urandom, 4'h8));

    // back-to-back create/kill pairs
    gaps_on   = 1'b0;
    first_pid = sb.next_id;
    send(create_cmd($urandom, $urandom, 4'h0));
    repeat (PAIR_COUNT) begin
      pid = sb.next_id;
      send(create_cmd($urandom, $urandom, 4'hF));
      send(kill_cmd(pid));
    end
    send(create_cmd($urandom, $urandom, 4'h0));
    send(kill_cmd(first_pid));
    send(kill_cmd(first_pid));
    send(kill_cmd(first_pid));

    // random traffic in phases: fill, tick, drain, mixed
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 90 && n < 140);
      phase   = (n / 35) % 4;
      case (phase)
        0:       begin c_w = 70; t_w = 15; end
        1:       begin c_w = 15; t_w = 65; end
        2:       begin c_w = 10; t_w = 30; end
        default: begin c_w = 30; t_w = 40; end
      endcase
      r  = $urandom_range(99, 0);
      r2 = $urandom_range(99, 0);
      if (r < c_w) begin
        now_v = ($urandom_range(9, 0) == 0) ? $urandom : now_t;
        if (r2 < 10)      ivl = 32'h0;
        else if (r2 < 20) ivl = $urandom;
        else if (r2 < 25) ivl = 32'hFFFF_FFFF;
        else              ivl = $urandom_range(400, 1);
        send(create_cmd(now_v, ivl, 4'($urandom_range(15, 0))));
      end else if (r < c_w + t_w) begin
        if (r2 < 4) now_t = 32'hFFFF_FFFF - $urandom_range(200, 0);
        else        now_t = now_t + $urandom_range(250, 0);
        now_v = ($urandom_range(9, 0) == 0) ? $urandom : now_t;
        send(tick_cmd(now_v, $urandom_range(99, 0) < 25));
      end else if (r < 97) begin
        if (r2 >= 20 && sb.pick_live_pid(pid)) send(kill_cmd(pid));
        else send(kill_cmd(16'($urandom)));
      end else begin
        in_data = noise_item();
        send({CMD_UNUSED, in_data[$bits(in_item_t)-3:0]});
      end
    end

    start   = 1'b0;
    in_data = noise_item();
    wait_n  = 0;
    while (sb.expected_events.size() != 0 && wait_n < 10000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_events.size() != 0)
      $error("%0d expected results never arrived", sb.expected_events.size());
    $display("Covered %0d transactions incl. back-to-back create/kill; %0d results checked.",
             sb.commands, sb.checked);
    $display("Creates refused on a full table: %0d, interrupt holds taken: %0d.",
             sb.full_seen, sb.holds_taken);
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
